// ----- rtl/multi_mode_prefix_scan_macros.svh -----
// Assertion macros for the multi-mode prefix scan block.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef MULTI_MODE_PREFIX_SCAN_MACROS_SVH
`define MULTI_MODE_PREFIX_SCAN_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted (active-low reset).
`define MMPS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define MMPS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMPS_ASSERT(name, clk, rst_n, prop, msg)
`define MMPS_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ----- rtl/mmps_pkg.sv -----
// Shared types and constants of the multi-mode prefix scan block.
// No dependencies.
`timescale 1ns / 1ps

package mmps_pkg;

  // Width of the element, term and result ports.
  localparam int IO_W   = 32;
  // Width of the mode register.
  localparam int MODE_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_INCL_SUM = 3'd0,
    MODE_EXCL_SUM = 3'd1,
    MODE_PROD     = 3'd2,
    MODE_MAX      = 3'd3,
    MODE_RECUR    = 3'd4
  } scan_mode_e;

endpackage

// ----- rtl/mmps_sat_mul.sv -----
// Saturating fixed-point multiplier: full product, round half away from zero,
// shift by the fraction bits, clip to the value range. No dependencies.
`timescale 1ns / 1ps

module mmps_sat_mul #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic signed [VALUE_WIDTH-1:0] a_i,
  input  logic signed [VALUE_WIDTH-1:0] b_i,
  output logic signed [VALUE_WIDTH-1:0] p_o,
  output logic                          sat_o
);

  localparam int PW = 2 * VALUE_WIDTH + 1;

  localparam logic [PW-1:0] RND       = (PW'(1) << FRAC_BITS) >> 1;
  localparam logic [PW-1:0] LIMIT_NEG = PW'(1) << (VALUE_WIDTH - 1);
  localparam logic [PW-1:0] LIMIT_POS = LIMIT_NEG - PW'(1);

  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic                     neg;
  logic [VALUE_WIDTH-1:0]   a_u, b_u, mag_a, mag_b;
  logic [2*VALUE_WIDTH-1:0] prod;
  logic [PW-1:0]            mag_r;
  logic [PW-1:0]            limit;
  logic [VALUE_WIDTH-1:0]   mag_lo;

  assign a_u   = a_i;
  assign b_u   = b_i;
  assign neg   = a_i[VALUE_WIDTH-1] ^ b_i[VALUE_WIDTH-1];
  // magnitude of the most negative value still fits as unsigned
  assign mag_a = a_i[VALUE_WIDTH-1] ? (~a_u + VALUE_WIDTH'(1)) : a_u;
  assign mag_b = b_i[VALUE_WIDTH-1] ? (~b_u + VALUE_WIDTH'(1)) : b_u;
  assign prod  = (2*VALUE_WIDTH)'(mag_a) * (2*VALUE_WIDTH)'(mag_b);
  assign mag_r = (PW'(prod) + RND) >> FRAC_BITS;
  assign limit = neg ? LIMIT_NEG : LIMIT_POS;
  assign mag_lo = mag_r[VALUE_WIDTH-1:0];

  always_comb begin
    if (mag_r > limit) begin
      sat_o = 1'b1;
      p_o   = neg ? VMIN : VMAX;
    end else begin
      sat_o = 1'b0;
      p_o   = neg ? signed'(~mag_lo + VALUE_WIDTH'(1)) : signed'(mag_lo);
    end
  end

endmodule

// ----- rtl/multi_mode_prefix_scan.sv -----
// Multi-mode streaming prefix scan: input register, combinational scan logic,
// result register. Depends on mmps_pkg, mmps_sat_mul and the macro header.
// Path: a beat is captured in the input register and moves through the scan
// logic into the result register once the result slot is free.
// Throughput: one beat per cycle while the receiver does not stall; set by the
// state feedback, which goes through one multiplier and one saturating add.
// Reset: async active low; clears valids, running state and mode (to 0).
`timescale 1ns / 1ps
`include "multi_mode_prefix_scan_macros.svh"

module multi_mode_prefix_scan
  import mmps_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // mode register write
  input  logic                     cfg_we_i,
  input  logic [MODE_W-1:0]        cfg_wdata_i,
  // element channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [IO_W-1:0]   elem_value_i,
  input  logic signed [IO_W-1:0]   elem_term_i,
  input  logic                     seq_start_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [IO_W-1:0]   scan_result_o,
  output logic signed [IO_W-1:0]   scan_term_o,
  output logic                     saturated_o
);

  localparam int W  = VALUE_WIDTH;
  // working width for port conversion: wide enough for both sides
  localparam int XW = (VALUE_WIDTH > IO_W) ? VALUE_WIDTH : IO_W;

  localparam logic signed [W-1:0]  VMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  VMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] VMAX_X = XW'(VMAX);
  localparam logic signed [XW-1:0] VMIN_X = XW'(VMIN);

  // 1.0 in the value format, clipped to the largest value if it won't fit
  localparam logic [XW:0] ONE_WIDE  = (XW+1)'(1) << FRAC_BITS;
  localparam logic [XW:0] VMAX_WIDE = ((XW+1)'(1) << (W - 1)) - (XW+1)'(1);
  localparam logic [XW:0] ONE_SEL   = (ONE_WIDE > VMAX_WIDE) ? VMAX_WIDE : ONE_WIDE;
  localparam logic signed [W-1:0] ONE = ONE_SEL[W-1:0];

  // Port value into the value range: {clipped, value}.
  function automatic logic [W:0] take_in(input logic signed [IO_W-1:0] raw);
    logic signed [XW-1:0] v;
    logic [W:0]           r;
    v = XW'(raw);
    if (v > VMAX_X) begin
      r = {1'b1, VMAX};
    end else if (v < VMIN_X) begin
      r = {1'b1, VMIN};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  // Saturating add: {clipped, sum}.
  function automatic logic [W:0] sat_add(input logic signed [W-1:0] a,
                                         input logic signed [W-1:0] b);
    logic signed [W:0] s;
    logic [W:0]        r;
    s = (W+1)'(a) + (W+1)'(b);
    if (!s[W] && s[W-1]) begin
      r = {1'b1, VMAX};
    end else if (s[W] && !s[W-1]) begin
      r = {1'b1, VMIN};
    end else begin
      r = {1'b0, s[W-1:0]};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- control
  logic [MODE_W-1:0] scan_mode_q;

  logic in_valid_q, out_valid_q;
  logic in_ready, out_ready, adv;

  // Result slot frees when empty or taken this cycle; the input slot refills
  // whenever its beat moves on, so a full pipe takes one beat per cycle while the receiver does not stall.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_ready;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode_q <= MODE_INCL_SUM;
    end else if (cfg_we_i) begin
      scan_mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // ---------------------------------------------------------- input register
  logic signed [IO_W-1:0] elem_value_q, elem_term_q;
  logic                   seq_start_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      elem_value_q <= elem_value_i;
      elem_term_q  <= elem_term_i;
      seq_start_q  <= seq_start_i;
    end
  end

  // ------------------------------------------------------------- scan logic
  // p_q: running sum/product/max, or product of the a terms in recurrence.
  // h_q: recurrence state h.
  logic signed [W-1:0] p_q, h_q, p_d, h_d;

  logic signed [W-1:0] x_val, b_val;
  logic                x_sat, b_sat;

  assign {x_sat, x_val} = take_in(elem_value_q);
  assign {b_sat, b_val} = take_in(elem_term_q);

  logic signed [W-1:0] m1_a, m1_p, m2_p;
  logic                m1_sat, m2_sat;

  // product mode seeds with 1.0 at a segment start
  assign m1_a = (scan_mode_q == MODE_PROD && seq_start_q) ? ONE : p_q;

  mmps_sat_mul #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_mul_prim (
    .a_i   (m1_a),
    .b_i   (x_val),
    .p_o   (m1_p),
    .sat_o (m1_sat)
  );

  // a*h for the recurrence
  mmps_sat_mul #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_mul_term (
    .a_i   (x_val),
    .b_i   (h_q),
    .p_o   (m2_p),
    .sat_o (m2_sat)
  );

  // one shared adder: running sum, or a*h + b in recurrence mode
  logic                recur;
  logic signed [W-1:0] add_a, add_b, add_v, max_base;
  logic                add_sat;

  assign recur = (scan_mode_q == MODE_RECUR);
  assign add_a = recur ? m2_p : (seq_start_q ? '0 : p_q);
  assign add_b = recur ? b_val : x_val;
  assign {add_sat, add_v} = sat_add(add_a, add_b);

  assign max_base = seq_start_q ? VMIN : p_q;

  logic signed [W-1:0] res_w, term_w;
  logic                sat_w;

  always_comb begin
    p_d    = p_q;
    h_d    = h_q;
    res_w  = '0;
    term_w = '0;
    sat_w  = 1'b0;
    case (scan_mode_q)
      MODE_INCL_SUM: begin
        p_d   = add_v;
        res_w = add_v;
        sat_w = x_sat | add_sat;
      end
      MODE_EXCL_SUM: begin
        p_d   = add_v;
        res_w = add_a;        // state before the add
        sat_w = x_sat | add_sat;
      end
      MODE_PROD: begin
        p_d   = m1_p;
        res_w = m1_p;
        sat_w = x_sat | m1_sat;
      end
      MODE_MAX: begin
        p_d   = (x_val > max_base) ? x_val : max_base;
        res_w = p_d;
        sat_w = x_sat;
      end
      MODE_RECUR: begin
        if (seq_start_q) begin
          // combining (a, b) with the identity (1.0, 0)
          p_d   = x_val;
          h_d   = b_val;
          sat_w = x_sat | b_sat;
        end else begin
          p_d   = m1_p;
          h_d   = add_v;
          sat_w = x_sat | b_sat | m1_sat | m2_sat | add_sat;
        end
        res_w  = p_d;
        term_w = h_d;
      end
      default: begin
        // unused modes: state held, result all zero
        sat_w = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
      h_q <= '0;
    end else if (adv) begin
      p_q <= p_d;
      h_q <= h_d;
    end
  end

  // --------------------------------------------------------- result register
  // values go out sign-extended or cut to the port width
  logic signed [XW-1:0] res_x, term_x;
  logic signed [IO_W-1:0] res_q, term_q;
  logic                   sat_q;

  assign res_x  = XW'(res_w);
  assign term_x = XW'(term_w);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q  <= res_x[IO_W-1:0];
      term_q <= term_x[IO_W-1:0];
      sat_q  <= sat_w;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scan_result_o = res_q;
  assign scan_term_o   = term_q;
  assign saturated_o   = sat_q;

  // -------------------------------------------------------------- checks
  `MMPS_ASSERT(a_state_hold, clk_i, rst_ni, !adv |=> $stable(p_q) && $stable(h_q), "scan state moved without a beat")
  `MMPS_ASSERT(a_term_only_recur, clk_i, rst_ni, adv && !recur |=> $stable(h_q), "recurrence state changed outside recurrence mode")
  `MMPS_ASSERT(a_adv_fills_out, clk_i, rst_ni, adv |=> out_valid_q, "advanced beat lost before result slot")
  `MMPS_ASSERT(a_in_hold, clk_i, rst_ni, in_valid_q && !out_ready |=> in_valid_q && $stable(elem_value_q) && $stable(seq_start_q), "held input beat overwritten")
  `MMPS_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_q && !in_valid_q, "pipe not empty in reset")

endmodule

// ----- verif/tb_multi_mode_prefix_scan.sv -----
// Self-checking testbench for multi_mode_prefix_scan: directed and random beats
// in all scan modes, checked against a cycle-free model of the running state.
// Depends on mmps_pkg and the multi_mode_prefix_scan RTL.
`timescale 1ns / 1ps

module tb_multi_mode_prefix_scan;
  import mmps_pkg::*;

  localparam int CLK_PERIOD = 4;
  // Drain time after the last expected beat is taken, to cover any pipeline tail.
  localparam int DRAIN_CYCLES = 4;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_PRINTED = 30;

  // Q16.16 landmarks.
  localparam logic signed [IO_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [IO_W-1:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [IO_W-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [IO_W-1:0] Q_HALF = 32'sh0000_8000;

  // Mode codes the package leaves undefined; the block must output zeros.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef enum int {VAL_ANY, VAL_SMALL, VAL_NEAR_ONE, VAL_EDGE} val_kind_e;

  typedef struct packed {
    logic signed [IO_W-1:0] result;
    logic signed [IO_W-1:0] term;
    logic                   sat;
  } scan_beat_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [MODE_W-1:0]      cfg_wdata_i = MODE_INCL_SUM;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [IO_W-1:0] elem_value_i = '0;
  logic signed [IO_W-1:0] elem_term_i = '0;
  logic                   seq_start_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [IO_W-1:0] scan_result_o;
  logic signed [IO_W-1:0] scan_term_o;
  logic                   saturated_o;

  multi_mode_prefix_scan dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .elem_value_i  (elem_value_i),
    .elem_term_i   (elem_term_i),
    .seq_start_i   (seq_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scan_result_o (scan_result_o),
    .scan_term_o   (scan_term_o),
    .saturated_o   (saturated_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Scan model: mirrors the block's mode register and running state. The
  // expected beat of every accepted element is queued in arrival order.
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]      model_mode = MODE_INCL_SUM;
  logic signed [IO_W-1:0] model_acc = '0;   // running sum / product / max / prod of a
  logic signed [IO_W-1:0] model_h = '0;     // recurrence state h
  bit                     model_sat;        // any clipping in the current step
  scan_beat_t             pending_results[$];

  int mismatch_count = 0;

  // Saturating Q16.16 add.
  function automatic logic signed [IO_W-1:0] clip_add(input logic signed [IO_W-1:0] a,
                                                      input logic signed [IO_W-1:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(Q_MAX)) begin
      model_sat = 1'b1;
      return Q_MAX;
    end
    if (s < longint'(Q_MIN)) begin
      model_sat = 1'b1;
      return Q_MIN;
    end
    return s[IO_W-1:0];
  endfunction

  // Q16.16 multiply: magnitude product, round half away from zero, then clip.
  // Negative results may reach one step further than positive ones.
  function automatic logic signed [IO_W-1:0] clip_mul(input logic signed [IO_W-1:0] a,
                                                      input logic signed [IO_W-1:0] b);
    logic                neg;
    longint unsigned     ma, mb, p, lim;
    logic [IO_W-1:0]     mag;
    neg = a[IO_W-1] ^ b[IO_W-1];
    ma = a[IO_W-1] ? -longint'(a) : longint'(a);
    mb = b[IO_W-1] ? -longint'(b) : longint'(b);
    p = (ma * mb + 64'd32768) >> 16;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (p > lim) begin
      model_sat = 1'b1;
      return neg ? Q_MIN : Q_MAX;
    end
    mag = p[IO_W-1:0];
    return neg ? -mag : mag;
  endfunction

  task automatic predict_scan(input logic signed [IO_W-1:0] x,
                              input logic signed [IO_W-1:0] b,
                              input logic start);
    scan_beat_t e;
    e = '0;
    model_sat = 1'b0;
    case (model_mode)
      MODE_INCL_SUM: begin
        if (start) model_acc = '0;
        model_acc = clip_add(model_acc, x);
        e.result = model_acc;
      end
      MODE_EXCL_SUM: begin
        // emits the sum before this element
        if (start) model_acc = '0;
        e.result = model_acc;
        model_acc = clip_add(model_acc, x);
      end
      MODE_PROD: begin
        if (start) model_acc = Q_ONE;
        model_acc = clip_mul(model_acc, x);
        e.result = model_acc;
      end
      MODE_MAX: begin
        if (start) model_acc = Q_MIN;
        if (x > model_acc) model_acc = x;
        e.result = model_acc;
      end
      MODE_RECUR: begin
        // start folds (a, b) into the identity (1.0, 0) without rounding
        if (start) begin
          model_acc = x;
          model_h = b;
        end else begin
          model_acc = clip_mul(model_acc, x);
          model_h = clip_add(clip_mul(x, model_h), b);
        end
        e.result = model_acc;
        e.term = model_h;
      end
      default: begin
        // spare codes: state frozen, all-zero beat
        model_sat = 1'b0;
      end
    endcase
    e.sat = model_sat;
    pending_results.push_back(e);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every beat taken from the output is matched against the
  // oldest queued expectation.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [IO_W-1:0] got,
                                 input logic [IO_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    scan_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", scan_result_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (scan_result_o !== want.result)
          report_mismatch("scan_result", scan_result_o, want.result);
        if (scan_term_o !== want.term)
          report_mismatch("scan_term", scan_term_o, want.term);
        if (saturated_o !== want.sat)
          report_mismatch("saturated", 32'(saturated_o), 32'(want.sat));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall density is redrawn from a free-running cycle count (zero density
  // included, so there are clean stretches). A hold-off request forces a solid stall.
  // ---------------------------------------------------------------------------
  bit receiver_idle = 1'b1;
  int hold_left = 0;
  int stall_pct = 0;
  int stall_cycle = 0;

  always @(posedge clk_i) begin
    stall_cycle++;
    if (stall_cycle % 48 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!receiver_idle || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, separated by random gaps while sender_idle is set. Every call
  // starts and ends right after a rising edge, so valid gets one update per
  // step and stays high across back-to-back beats.
  // ---------------------------------------------------------------------------
  bit sender_idle = 1'b1;
  int burst_left = 0;

  task automatic send_elem(input logic signed [IO_W-1:0] value,
                           input logic signed [IO_W-1:0] term,
                           input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = sender_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    elem_value_i <= value;
    elem_term_i  <= term;
    seq_start_i  <= start;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    predict_scan(value, term, start);
  endtask

  // Drop valid and let every outstanding beat come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mode writes only happen with the pipeline empty.
  task automatic set_mode(input logic [MODE_W-1:0] m);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_mode = m;
  endtask

  function automatic logic signed [IO_W-1:0] pick_q(input val_kind_e kind);
    logic signed [IO_W-1:0] v;
    case (kind)
      VAL_SMALL: v = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      VAL_NEAR_ONE: begin
        v = Q_ONE + $signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000;
        if ($urandom_range(0, 1)) v = -v;
      end
      VAL_EDGE: begin
        case ($urandom_range(0, 6))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = '0;
          3: v = -1;
          4: v = 1;
          5: v = Q_ONE;
          default: v = -Q_ONE;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Products want factors near 1.0 or they pin at the rails within a few beats.
  function automatic val_kind_e pick_kind(input logic [MODE_W-1:0] m);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return VAL_ANY;
    if (r < 20) return VAL_EDGE;
    if (m == MODE_PROD || m == MODE_RECUR) return VAL_NEAR_ONE;
    return VAL_SMALL;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Mode register resets to inclusive sum; no start after reset means the
  // sum continues from zero.
  task automatic test_reset_state();
    send_elem(32'sh0005_0000, '0, 1'b0);
    send_elem(Q_MAX, '0, 1'b0);          // clips high
    send_elem(Q_MIN, Q_MAX, 1'b1);
    send_elem(-1, '0, 1'b0);             // clips low
  endtask

  task automatic test_excl_sum();
    set_mode(MODE_EXCL_SUM);
    send_elem(32'sh0003_0000, '0, 1'b0); // mode switch mid segment: state reused
    send_elem(Q_MAX, '0, 1'b1);          // first beat of a segment reads zero
    send_elem(1, '0, 1'b0);              // reports MAX, then clips
  endtask

  task automatic test_product();
    set_mode(MODE_PROD);
    send_elem(32'sh0002_0000, '0, 1'b1);
    send_elem(Q_HALF, '0, 1'b0);
    send_elem(Q_HALF, '0, 1'b1);
    send_elem(1, '0, 1'b0);              // tie rounds up
    send_elem(Q_HALF, '0, 1'b1);
    send_elem(-1, '0, 1'b0);             // tie rounds away from zero
    send_elem(Q_MIN, '0, 1'b1);          // exact MIN
    send_elem(Q_MIN, '0, 1'b0);          // huge positive, clips
    send_elem(Q_MIN, '0, 1'b1);
    send_elem(-Q_ONE, '0, 1'b0);         // +2^31 just past MAX
  endtask

  task automatic test_running_max();
    set_mode(MODE_MAX);
    send_elem(32'shFFFB_0000, '0, 1'b0);
    send_elem(Q_MIN, '0, 1'b1);
    send_elem(32'shFFFB_0000, '0, 1'b0);
    send_elem(Q_MAX, '0, 1'b0);
  endtask

  task automatic test_recurrence();
    set_mode(MODE_RECUR);
    send_elem(Q_ONE, 32'sh0002_0000, 1'b1);
    send_elem(Q_HALF, Q_ONE, 1'b0);
    send_elem(Q_MAX, Q_MAX, 1'b0);       // the a*h product and the add clip
    send_elem(Q_MIN, Q_MIN, 1'b1);
    send_elem(Q_MIN, Q_MIN, 1'b0);
  endtask

  // Spare codes output zeros and leave the state alone.
  task automatic test_spare_modes();
    set_mode(MODE_SPARE_LO);
    send_elem(Q_MAX, Q_MIN, 1'b1);
    set_mode(MODE_SPARE_HI);
    send_elem(Q_MIN, Q_MAX, 1'b0);
    set_mode(MODE_INCL_SUM);
    send_elem(Q_ONE, '0, 1'b0);
  endtask

  // Phases of random mode, each a run of segments that open with a start;
  // some segments lack it and some carry a stray start mid segment.
  task automatic test_random_segments(input int target);
    int sent;
    int phase_end;
    int seg_len;
    logic [MODE_W-1:0] m;
    logic st;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 99) < 4)
        m = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      else
        m = MODE_W'($urandom_range(MODE_INCL_SUM, MODE_RECUR));
      set_mode(m);
      sender_idle   = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      phase_end = sent + $urandom_range(40, 120);
      while (sent < phase_end) begin
        seg_len = $urandom_range(1, 24);
        for (int i = 0; i < seg_len; i++) begin
          if (i == 0) st = ($urandom_range(0, 9) != 0);
          else st = ($urandom_range(0, 99) < 3);
          send_elem(pick_q(pick_kind(m)), pick_q(pick_kind(m)), st);
          sent++;
        end
      end
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps pushing, so
  // the pipeline fills and back-pressure reaches the input.
  task automatic test_back_pressure();
    set_mode(MODE_INCL_SUM);
    sender_idle = 1'b0;
    hold_left = HOLD_OFF_CYCLES;
    for (int i = 0; i < 60; i++)
      send_elem(pick_q(VAL_SMALL), pick_q(VAL_ANY), (i % 20 == 0));
    sender_idle = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_excl_sum();
    test_product();
    test_running_max();
    test_recurrence();
    test_spare_modes();
    test_back_pressure();
    test_random_segments(950);
    // highest defined mode last, then back to reset value
    set_mode(MODE_RECUR);
    set_mode(MODE_INCL_SUM);
    wait_idle();
    if (mismatch_count == 0)
      $display("PASS multi_mode_prefix_scan");
    else
      $display("FAIL multi_mode_prefix_scan");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout, %0d beats outstanding", pending_results.size());
    $display("FAIL multi_mode_prefix_scan");
    $finish;
  end

endmodule
